FILE: hw/rtl/fsmu_pkg.sv
// shared types and constants for the first substring match unit
`default_nettype none

package fsmu_pkg;

    localparam int CH_W  = 8;
    localparam int POS_W = 16;

    // item kinds on the input channel
    localparam logic ACT_PATTERN = 1'b0;
    localparam logic ACT_TEXT    = 1'b1;

    typedef struct packed {
        logic            action;
        logic [CH_W-1:0] ch;
        logic            last;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] text_length;
    } t_out;

    // shift enables that run along the cell row
    typedef struct packed {
        logic shift_w;
        logic shift_p;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/fsmu_cell.sv
// one comparator cell: a window byte and a reversed pattern byte
`default_nettype none

module fsmu_cell (
    input  wire logic                     i_clk,
    input  wire fsmu_pkg::t_cell_ctl      i_ctl,
    input  wire logic [fsmu_pkg::CH_W-1:0] i_w,
    input  wire logic [fsmu_pkg::CH_W-1:0] i_p,
    output logic [fsmu_pkg::CH_W-1:0]      o_w,
    output logic [fsmu_pkg::CH_W-1:0]      o_p,
    output logic                           o_hit
);
    import fsmu_pkg::*;

    logic [CH_W-1:0] r_w;
    logic [CH_W-1:0] r_p;

    // window and pattern bytes move one cell along on their shift enables
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_w) begin
            r_w <= i_w;
        end
        if (i_ctl.shift_p) begin
            r_p <= i_p;
        end
    end

    // the byte arriving from the neighbour is this cell's new window byte
    assign o_hit = (i_w == r_p);
    assign o_w   = r_w;
    assign o_p   = r_p;

endmodule

`default_nettype wire

FILE: hw/rtl/first_substring_match_unit.sv
// Finds the first occurrence of a loaded pattern in a streamed text.
// Input channel (i_in_valid / o_in_stall / i_in_data): action 0 appends a
// pattern byte, action 1 is a text byte; last on a text byte ends the run.
// Pattern bytes shift into a row of MAX_PATTERN cells in reverse order, text
// bytes shift through the same row, and every cell compares its pair at once;
// a reduction over the active cells flags a full match in the same cycle.
// Output channel (o_out_valid / i_out_stall / o_out_data): one transaction
// per run, carrying found, start position and saturated text length.
// Throughput: one item per cycle unless the input stalls. The result of the
// last text byte is registered and offered on the cycle after it is accepted.
// While a result is held because the receiver stalls, the input is stalled
// too, so no item is accepted until the result has been taken.
// Reset clears the pattern length, text count, match state and output valid;
// the pattern bytes keep their contents but count only once re-appended.
`default_nettype none

module first_substring_match_unit #(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_TEXT    = 65535
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire fsmu_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output fsmu_pkg::t_out      o_out_data
);
    import fsmu_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int CW = $clog2(MAX_TEXT + 1);
    localparam int SW = (CW > LW) ? CW : LW;

    logic [LW-1:0] r_len, n_len;
    logic [CW-1:0] r_count, n_count;
    logic          r_seen, n_seen;
    logic [SW-1:0] r_start, n_start;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic          v_take;
    logic          v_text;
    t_cell_ctl     v_ctl;
    logic [CH_W-1:0] v_w [MAX_PATTERN+1];
    logic [CH_W-1:0] v_p [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] v_ok;
    logic          v_match;
    logic [SW-1:0] v_count_ext;
    logic [SW-1:0] v_len_ext;
    logic [SW-1:0] v_pos;
    logic [SW+POS_W-1:0] v_pos_wide;
    logic [SW+POS_W-1:0] v_cnt_wide;

    // handshake
    assign o_in_stall = r_out_valid & i_out_stall;
    assign v_take     = i_in_valid & ~o_in_stall;
    assign v_text     = v_take & (i_in_data.action == ACT_TEXT);

    // row control
    always_comb begin
        v_ctl.shift_w = v_text;
        v_ctl.shift_p = v_take & (i_in_data.action == ACT_PATTERN)
                        & (r_len < LW'(MAX_PATTERN));
    end

    assign v_w[0] = i_in_data.ch;
    assign v_p[0] = i_in_data.ch;

    // comparator row
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic v_hit;
        fsmu_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (v_ctl),
            .i_w   (v_w[k]),
            .i_p   (v_p[k]),
            .o_w   (v_w[k+1]),
            .o_p   (v_p[k+1]),
            .o_hit (v_hit)
        );
        assign v_ok[k] = v_hit | (LW'(k) >= r_len);
    end

    // run state update
    always_comb begin
        n_len   = r_len;
        n_count = r_count;
        n_seen  = r_seen;
        n_start = r_start;
        v_match = 1'b0;
        v_count_ext = '0;
        v_len_ext   = SW'(r_len);
        if (v_ctl.shift_p) begin
            n_len = r_len + LW'(1);
        end
        if (v_text && (r_count < CW'(MAX_TEXT))) begin
            n_count     = r_count + CW'(1);
            v_count_ext = SW'(n_count);
            v_match     = (r_len != '0) && (v_count_ext >= v_len_ext) && (&v_ok);
            if (!r_seen && v_match) begin
                n_seen  = 1'b1;
                n_start = v_count_ext - v_len_ext;
            end
        end
    end

    // result formation and output register
    always_comb begin
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;
        if (n_seen) begin
            v_pos = n_start;
        end else if (r_len == '0) begin
            v_pos = '0;
        end else begin
            v_pos = SW'(n_count);
        end
        v_pos_wide = {{POS_W{1'b0}}, v_pos};
        v_cnt_wide = {{POS_W{1'b0}}, SW'(n_count)};
        if (v_text && i_in_data.last) begin
            n_out_valid     = 1'b1;
            n_out.found     = n_seen | (r_len == '0);
            n_out.position  = v_pos_wide[POS_W-1:0];
            n_out.text_length = v_cnt_wide[POS_W-1:0];
        end
    end

    // registers; the end of a run clears the run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_count     <= '0;
            r_seen      <= 1'b0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (v_text && i_in_data.last) begin
                r_len   <= '0;
                r_count <= '0;
                r_seen  <= 1'b0;
                r_start <= '0;
            end else begin
                r_len   <= n_len;
                r_count <= n_count;
                r_seen  <= n_seen;
                r_start <= n_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// testbench for the first substring match unit: scoreboard with a search model and stream drivers

// predicts the search report of every run and checks the reports that come out
class search_scoreboard #(int PAT_DEPTH = 64, int TEXT_CAP = 65535);
    logic [7:0]     pat_bytes [PAT_DEPTH];
    int unsigned    pat_len;
    logic [7:0]     window [PAT_DEPTH];
    int unsigned    text_seen;
    bit             hit_seen;
    int unsigned    hit_start;
    fsmu_pkg::t_out pending_reports [$];
    int             failures;

    function new();
        foreach (pat_bytes[k]) pat_bytes[k] = 8'h00;
        failures = 0;
        clear_run();
    endfunction

    // run state goes back to zero, pattern bytes are kept
    function void clear_run();
        pat_len = 0;
        foreach (window[k]) window[k] = 8'h00;
        text_seen = 0;
        hit_seen = 1'b0;
        hit_start = 0;
    endfunction

    // update the search state with one accepted transaction
    function void note_item(fsmu_pkg::t_in item);
        int             k;
        bit             hit;
        fsmu_pkg::t_out report;
        if (item.action == fsmu_pkg::ACT_PATTERN) begin
            // bytes past the store depth are dropped
            if (pat_len < PAT_DEPTH) begin
                pat_bytes[pat_len] = item.ch;
                pat_len++;
            end
            return;
        end
        // newest text byte sits at index 0
        for (k = PAT_DEPTH - 1; k > 0; k--) window[k] = window[k - 1];
        window[0] = item.ch;
        // once the count saturates no new match can be latched
        if (text_seen < TEXT_CAP) begin
            text_seen++;
            if (!hit_seen && pat_len != 0 && text_seen >= pat_len) begin
                hit = 1'b1;
                for (k = 0; k < int'(pat_len); k++) begin
                    if (window[k] != pat_bytes[pat_len - 1 - k]) hit = 1'b0;
                end
                if (hit) begin
                    hit_seen = 1'b1;
                    hit_start = text_seen - pat_len;
                end
            end
        end
        if (!item.last) return;
        // empty pattern counts as found at the start
        report.found = hit_seen || (pat_len == 0);
        if (hit_seen) report.position = 16'(hit_start);
        else if (pat_len == 0) report.position = 16'd0;
        else report.position = 16'(text_seen);
        report.text_length = 16'(text_seen);
        pending_reports.push_back(report);
        clear_run();
    endfunction

    // compare one accepted report with the oldest prediction
    function void check_result(fsmu_pkg::t_out got);
        fsmu_pkg::t_out want;
        if (pending_reports.size() == 0) begin
            $error("unexpected report: found %0d, position %0d, text_length %0d",
                   got.found, got.position, got.text_length);
            failures++;
            return;
        end
        want = pending_reports.pop_front();
        if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            failures++;
        end
        if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            failures++;
        end
        if (got.text_length !== want.text_length) begin
            $error("text_length: expected %0d, actual %0d", want.text_length, got.text_length);
            failures++;
        end
    endfunction
endclass

module testbench;
    import fsmu_pkg::*;

    localparam int MAX_PAT      = 64;
    localparam int TEXT_CAP     = 65535;
    localparam int ITEM_TARGET  = 1650;
    localparam int QUIET_TAIL   = 250;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 4_000_000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;

    search_scoreboard #(MAX_PAT, TEXT_CAP) board;
    bit quiet;
    int items_sent;
    int cycle_count;
    int stall_left;

    first_substring_match_unit #(
        .MAX_PATTERN(MAX_PAT),
        .MAX_TEXT   (TEXT_CAP)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stalls in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) stall_left--;
        else if (!quiet && i_rst_n && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
        out_stall <= (stall_left > 0);
    end

    // report monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) board.check_result(out_data);
    end

    function automatic logic [7:0] pick_byte(bit narrow, logic [7:0] sym_a, logic [7:0] sym_b);
        if (narrow) return $urandom_range(0, 1) ? sym_a : sym_b;
        return 8'($urandom);
    endfunction

    // one input transaction, with an optional idle burst ahead of it
    task automatic send_item(input logic act, input logic [7:0] ch, input logic last);
        t_in item;
        int  gap;
        item.action = act;
        item.ch     = ch;
        item.last   = last;
        if (!quiet && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (in_stall);
        board.note_item(item);
        items_sent++;
        @(negedge i_clk);
    endtask

    // hold the input until every predicted report has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending_reports.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // pattern then text, the text sometimes carrying a copy of the pattern
    task automatic random_search(input int plen, input int tlen);
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        logic [7:0] sym_a;
        logic [7:0] sym_b;
        bit         narrow;
        int         keep;
        int         at;
        int         k;
        narrow = ($urandom_range(0, 3) != 0);
        sym_a  = 8'($urandom);
        sym_b  = 8'($urandom);
        for (k = 0; k < plen; k++) pat.push_back(pick_byte(narrow, sym_a, sym_b));
        for (k = 0; k < tlen; k++) txt.push_back(pick_byte(narrow, sym_a, sym_b));
        keep = (plen < MAX_PAT) ? plen : MAX_PAT;
        if (keep != 0 && tlen >= keep && $urandom_range(0, 1) == 1) begin
            at = $urandom_range(0, tlen - keep);
            for (k = 0; k < keep; k++) txt[at + k] = pat[k];
        end
        foreach (pat[k]) send_item(ACT_PATTERN, pat[k], $urandom_range(0, 7) == 0);
        for (k = 0; k < tlen; k++) begin
            // now and then the pattern grows in the middle of the text
            if ($urandom_range(0, 19) == 0)
                send_item(ACT_PATTERN, pick_byte(narrow, sym_a, sym_b),
                          1'($urandom_range(0, 1)));
            send_item(ACT_TEXT, txt[k], k == tlen - 1);
        end
    endtask

    // main sequence
    initial begin
        int start;
        int r;
        board      = new();
        quiet      = 1'b0;
        items_sent = 0;
        cycle_count = 0;
        stall_left = 0;
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern, text at both byte extremes
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'hFF, 1'b1);
        // plain match one byte in
        send_item(ACT_PATTERN, 8'h00, 1'b0);
        send_item(ACT_PATTERN, 8'hFF, 1'b0);
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'hFF, 1'b1);
        // text shorter than the pattern
        send_item(ACT_PATTERN, 8'h01, 1'b0);
        send_item(ACT_PATTERN, 8'h02, 1'b0);
        send_item(ACT_PATTERN, 8'h03, 1'b0);
        send_item(ACT_TEXT, 8'h01, 1'b0);
        send_item(ACT_TEXT, 8'h02, 1'b1);
        // pattern grows mid-run, last flag on a pattern byte is ignored
        send_item(ACT_PATTERN, 8'h80, 1'b0);
        send_item(ACT_TEXT, 8'h7F, 1'b0);
        send_item(ACT_PATTERN, 8'h01, 1'b1);
        send_item(ACT_TEXT, 8'h80, 1'b0);
        send_item(ACT_TEXT, 8'h01, 1'b1);
        // single byte pattern that never occurs
        send_item(ACT_PATTERN, 8'hAA, 1'b0);
        send_item(ACT_TEXT, 8'h55, 1'b1);
        wait_drained();

        // pattern longer than the store
        random_search(70, 90);

        // random runs, mostly short patterns over small alphabets
        start = items_sent;
        while (items_sent - start < ITEM_TARGET) begin
            if (items_sent - start >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 3) random_search($urandom_range(60, 72), $urandom_range(60, 120));
            else if (r < 12) random_search($urandom_range(9, 64), $urandom_range(1, 120));
            else random_search($urandom_range(0, 8), $urandom_range(1, 40));
            if (!quiet && $urandom_range(0, 29) == 0) wait_drained();
        end

        // let the last reports out
        quiet = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.failures == 0 && board.pending_reports.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
